### rtl/tsps_pkg.sv
// Package for the time-slot phase scheduler: item types, register map,
// state encoding and sizing constants. No dependencies.
`default_nettype none

package tsps_pkg;

    // Sizing
    localparam int MAX_MODULES_DEF = 4;
    localparam int SLOT_REGS       = 4;
    localparam int DIVIDEND_W      = 32;
    localparam int ROUND_W         = 18;
    localparam int PADDR_W         = 5;

    localparam logic [15:0] ALIGN_PERIOD_RST = 16'd1000;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_MODULE_COUNT = 3'd0;
    localparam logic [2:0] REG_SLOT_LEN_0   = 3'd1;
    localparam logic [2:0] REG_SLOT_LEN_1   = 3'd2;
    localparam logic [2:0] REG_SLOT_LEN_2   = 3'd3;
    localparam logic [2:0] REG_SLOT_LEN_3   = 3'd4;
    localparam logic [2:0] REG_ALIGN_PERIOD = 3'd5;
    localparam logic [2:0] REG_CLOCK_SKEW   = 3'd6;

    typedef struct packed {
        logic [31:0] mono_ms;
        logic [26:0] day_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] slot_ms;
        logic        phase_changed;
        logic [1:0]  old_phase;
        logic        aligned;
        logic        first_phase;
        logic        idle;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SEARCH,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

### rtl/time_slot_phase_scheduler_unit.sv
// Top level of the time-slot phase scheduler: APB register file, sequencer,
// slot search and output register. Depends on tsps_pkg and tsps_mod_unit.
//
// Each input item is one phase-end event. The block answers with exactly one
// result item: it either advances the round-robin phase and reports the next
// slot length, or, on the first event and whenever more than align_period_ms
// has passed, realigns the phase to (day_ms + clock_skew_ms) modulo the round
// length and reports the time left in that slot. From acceptance to the result
// register an item passes a setup state, the bit-serial modulo unit (one
// dividend bit per cycle), a slot walk of up to three steps and a finish
// state. Events with no modules or a zero round skip the modulo unit and
// the slot walk and give an idle result. One item is in work at a time; a
// new item is accepted while the previous result still waits in the output
// register, and the finish state holds until that register is free.
`default_nettype none

module time_slot_phase_scheduler_unit
    import tsps_pkg::*;
#(
    parameter int P_MAX_MODULES = MAX_MODULES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Event input
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_item           i_in_data,
    // Result output
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out_data,
    // Configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int LP_CAP = (P_MAX_MODULES < SLOT_REGS) ? P_MAX_MODULES : SLOT_REGS;

    // Configuration registers
    logic [2:0]  r_module_count;
    logic [15:0] r_slot_len_0;
    logic [15:0] r_slot_len_1;
    logic [15:0] r_slot_len_2;
    logic [15:0] r_slot_len_3;
    logic [15:0] r_align_period;
    logic [15:0] r_clock_skew;

    // Scheduler state
    logic [1:0]  r_cur_phase;
    logic [31:0] r_last_align;
    logic        r_aligned_before;

    // Per-item work registers
    t_state               r_state;
    t_state               n_state;
    logic [31:0]          r_mono;
    logic [26:0]          r_day;
    logic [2:0]           r_n;
    logic                 r_idle;
    logic                 r_do_align;
    logic [1:0]           r_next_adv;
    logic [15:0]          r_dur_adv;
    logic [ROUND_W-1:0]   r_into;
    logic [1:0]           r_cph;
    logic [ROUND_W-1:0]   r_acc;
    logic [15:0]          r_sq [SLOT_REGS-1];

    // Output register
    logic                 r_out_valid;
    t_out_item            r_out_data;

    logic [2:0]           w_idx;
    logic                 w_wr;
    logic [2:0]           w_n;
    logic [ROUND_W-1:0]   w_round;
    logic [31:0]          w_point;
    logic [2:0]           w_adv;
    logic [1:0]           w_next_adv;
    logic [15:0]          w_dur_adv;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [ROUND_W-1:0]   w_div_rem;
    logic                 w_step;
    logic [ROUND_W-1:0]   w_diff;
    logic [15:0]          w_remaining;
    logic [1:0]           w_new_phase;
    logic [15:0]          w_new_dur;
    logic                 w_in_acc;
    logic                 w_out_load;
    t_out_item            w_out_item;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_count <= '0;
            r_slot_len_0   <= '0;
            r_slot_len_1   <= '0;
            r_slot_len_2   <= '0;
            r_slot_len_3   <= '0;
            r_align_period <= ALIGN_PERIOD_RST;
            r_clock_skew   <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_MODULE_COUNT: r_module_count <= pwdata[2:0];
                REG_SLOT_LEN_0:   r_slot_len_0   <= pwdata[15:0];
                REG_SLOT_LEN_1:   r_slot_len_1   <= pwdata[15:0];
                REG_SLOT_LEN_2:   r_slot_len_2   <= pwdata[15:0];
                REG_SLOT_LEN_3:   r_slot_len_3   <= pwdata[15:0];
                REG_ALIGN_PERIOD: r_align_period <= pwdata[15:0];
                REG_CLOCK_SKEW:   r_clock_skew   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (w_idx)
            REG_MODULE_COUNT: prdata = {29'd0, r_module_count};
            REG_SLOT_LEN_0:   prdata = {16'd0, r_slot_len_0};
            REG_SLOT_LEN_1:   prdata = {16'd0, r_slot_len_1};
            REG_SLOT_LEN_2:   prdata = {16'd0, r_slot_len_2};
            REG_SLOT_LEN_3:   prdata = {16'd0, r_slot_len_3};
            REG_ALIGN_PERIOD: prdata = {16'd0, r_align_period};
            REG_CLOCK_SKEW:   prdata = {16'd0, r_clock_skew};
            default:          prdata = '0;
        endcase
    end

    // Setup: module count, round length, skewed time of day, plain advance
    assign w_n = (r_module_count > 3'(LP_CAP)) ? 3'(LP_CAP) : r_module_count;

    assign w_round = ((w_n > 3'd0) ? ROUND_W'(r_slot_len_0) : '0)
                   + ((w_n > 3'd1) ? ROUND_W'(r_slot_len_1) : '0)
                   + ((w_n > 3'd2) ? ROUND_W'(r_slot_len_2) : '0)
                   + ((w_n > 3'd3) ? ROUND_W'(r_slot_len_3) : '0);

    assign w_point = {5'd0, r_day} + {{16{r_clock_skew[15]}}, r_clock_skew};

    assign w_adv      = {1'b0, r_cur_phase} + 3'd1;
    assign w_next_adv = (w_adv >= w_n) ? 2'd0 : w_adv[1:0];

    always_comb begin
        case (w_next_adv)
            2'd0:    w_dur_adv = r_slot_len_0;
            2'd1:    w_dur_adv = r_slot_len_1;
            2'd2:    w_dur_adv = r_slot_len_2;
            default: w_dur_adv = r_slot_len_3;
        endcase
    end

    // Modulo of the skewed time of day by the round length
    tsps_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_point),
        .i_divisor  (w_round),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // Slot walk: step while a later slot exists and the prefix sum is short
    assign w_step = ({1'b0, r_cph} + 3'd1 < r_n) && (r_acc < r_into);

    // Finish: time left in the located slot, saturated to 16 bits
    assign w_diff      = r_acc - r_into;
    assign w_remaining = (r_acc < r_into) ? 16'd0 :
                         (w_diff > ROUND_W'(16'hFFFF)) ? 16'hFFFF : w_diff[15:0];
    assign w_new_phase = r_do_align ? r_cph : r_next_adv;
    assign w_new_dur   = r_do_align ? w_remaining : r_dur_adv;

    // Assemble the result item of the finish cycle
    always_comb begin
        w_out_item = '0;
        if (r_idle) begin
            w_out_item.idle = 1'b1;
        end else begin
            w_out_item.phase         = w_new_phase;
            w_out_item.slot_ms       = w_new_dur;
            w_out_item.phase_changed = (w_new_phase != r_cur_phase);
            w_out_item.old_phase     = r_cur_phase;
            w_out_item.aligned       = r_do_align;
            w_out_item.first_phase   = (w_new_phase == 2'd0);
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake controls
    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (w_n == 3'd0 || w_round == '0) begin
                    n_state = ST_FIN;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (!w_step) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_in_acc = i_in_valid && !o_in_stall;

    // Per-item datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mono <= i_in_data.mono_ms;
            r_day  <= i_in_data.day_ms;
        end
        if (r_state == ST_PREP) begin
            r_n        <= w_n;
            r_idle     <= (w_n == 3'd0) || (w_round == '0);
            r_do_align <= !r_aligned_before || ((r_mono - r_last_align) > {16'd0, r_align_period});
            r_next_adv <= w_next_adv;
            r_dur_adv  <= w_dur_adv;
            r_cph      <= 2'd0;
            r_acc      <= ROUND_W'(r_slot_len_0);
            r_sq[0]    <= r_slot_len_1;
            r_sq[1]    <= r_slot_len_2;
            r_sq[2]    <= r_slot_len_3;
        end
        if (r_state == ST_DIV && w_div_done) begin
            r_into <= w_div_rem;
        end
        // Advance one slot and shift the queue of remaining lengths
        if (r_state == ST_SEARCH && w_step) begin
            r_cph   <= r_cph + 2'd1;
            r_acc   <= r_acc + ROUND_W'(r_sq[0]);
            r_sq[0] <= r_sq[1];
            r_sq[1] <= r_sq[2];
            r_sq[2] <= '0;
        end
        if (w_out_load) begin
            r_out_data <= w_out_item;
        end
    end

    // Scheduler state update at result time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_phase      <= '0;
            r_last_align     <= '0;
            r_aligned_before <= 1'b0;
        end else if (w_out_load) begin
            if (r_idle) begin
                if (r_n == 3'd0) begin
                    r_cur_phase <= '0;
                end
            end else begin
                r_cur_phase <= w_new_phase;
                if (r_do_align) begin
                    r_last_align     <= r_mono;
                    r_aligned_before <= 1'b1;
                end
            end
        end
    end

    // Output valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("modulo result outside divide state");

    a_accept_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == ST_PREP)
        else $error("accepted item did not enter setup");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.idle) |->
        (o_out_data.phase == 2'd0 && o_out_data.slot_ms == 16'd0 &&
         !o_out_data.aligned && !o_out_data.phase_changed))
        else $error("idle result carries nonzero fields");

    a_phase_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        o_out_data.phase_changed == (o_out_data.phase != o_out_data.old_phase))
        else $error("phase_changed inconsistent with phases");

    a_first_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.idle) |->
        o_out_data.first_phase == (o_out_data.phase == 2'd0))
        else $error("first_phase inconsistent with phase");

endmodule

`default_nettype wire

### rtl/tsps_mod_unit.sv
// Bit-serial restoring remainder unit: dividend modulo divisor, one
// dividend bit per cycle. Depends on tsps_pkg.
`default_nettype none

module tsps_mod_unit
    import tsps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [ROUND_W-1:0]    i_divisor,
    output logic                       o_done,
    output logic [ROUND_W-1:0]         o_rem
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_shift;
    logic [ROUND_W-1:0]    r_rem;
    logic [ROUND_W-1:0]    r_divisor;

    logic [ROUND_W:0]      w_trial;
    logic [ROUND_W:0]      w_diff;

    // Bring in the next dividend bit and try one subtraction
    assign w_trial = {r_rem, r_shift[DIVIDEND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};

    // Control: busy while every dividend bit is shifted through, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the dividend out, keep the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift   <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_shift <= {r_shift[DIVIDEND_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_divisor}) begin
                r_rem <= w_diff[ROUND_W-1:0];
            end else begin
                r_rem <= w_trial[ROUND_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### tb/time_slot_phase_scheduler_unit_tb.sv
// Self-checking testbench for time_slot_phase_scheduler_unit: random-gap event driver,
// randomly stalling result monitor, APB register writes and a phase/slot predictor.
// Depends on tsps_pkg and the scheduler RTL only.
`default_nettype none

module time_slot_phase_scheduler_unit_tb
    import tsps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DAY_MS      = 86_400_000;
    localparam int unsigned DRAIN_PAD   = 48;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned RAND_PHASES = 10;
    localparam int unsigned PHASE_ITEMS = 60;
    localparam logic [2:0]  REG_UNUSED  = 3'd7;

    typedef struct {
        t_in_item    ev;
        int unsigned gap;
    } t_pending;

    // Clock, reset and DUT inputs, all known from time zero
    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               in_valid = 1'b0;
    t_in_item           in_data  = '0;
    logic               out_stall = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out_data;
    logic [31:0]        prdata;
    logic               pready;

    // Register mirror and scheduler state of the predictor
    logic [2:0]  cfg_count    = '0;
    logic [15:0] cfg_slot [4] = '{default: '0};
    logic [15:0] cfg_align    = ALIGN_PERIOD_RST;
    logic [15:0] cfg_skew     = '0;
    logic [1:0]  sched_phase  = '0;
    logic [31:0] last_sync_ms = '0;
    bit          synced       = 1'b0;

    t_pending    pending_q [$];
    t_out_item   expected_q [$];
    int unsigned wait_cnt = 0;
    int unsigned fail_cnt = 0;
    bit          quiet    = 1'b0;
    bit          hold_req = 1'b0;

    time_slot_phase_scheduler_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    // Advance the phase or realign it to the wall clock; return the expected result
    function automatic t_out_item predict_event(t_in_item ev);
        t_out_item   r;
        int unsigned n, span, old_ph, nxt, offs, walk, acc, remain, dur;
        logic [31:0] point, elapsed;
        bit          realign;
        r = '0;
        n = (cfg_count > 3'd4) ? 4 : cfg_count;
        if (n == 0) begin
            sched_phase = '0;
            r.idle = 1'b1;
            return r;
        end
        span = 0;
        for (int i = 0; i < n; i++) span += cfg_slot[i];
        if (span == 0) begin
            r.idle = 1'b1;
            return r;
        end
        old_ph = sched_phase;
        nxt = old_ph + 1;
        if (nxt >= n) nxt = 0;

        // Locate the skewed time of day within the round
        point = {5'b0, ev.day_ms} + {{16{cfg_skew[15]}}, cfg_skew};
        offs = point % span;
        walk = 0;
        acc = cfg_slot[0];
        while (walk + 1 < n && acc < offs) begin
            walk++;
            acc += cfg_slot[walk];
        end
        remain = (acc >= offs) ? acc - offs : 0;
        if (remain > 65535) remain = 65535;

        dur = cfg_slot[nxt];
        elapsed = ev.mono_ms - last_sync_ms;
        realign = !synced || (elapsed > {16'b0, cfg_align});
        if (realign) begin
            nxt = walk;
            last_sync_ms = ev.mono_ms;
            synced = 1'b1;
            dur = remain;
        end
        sched_phase = nxt[1:0];

        r.phase         = nxt[1:0];
        r.slot_ms       = dur[15:0];
        r.phase_changed = (nxt != old_ph);
        r.old_phase     = old_ph[1:0];
        r.aligned       = realign;
        r.first_phase   = (nxt == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // Driver: present queued items after their drawn gap, predict on acceptance
    always @(posedge i_clk) begin : event_driver
        bit slot_free;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            wait_cnt <= 0;
        end else begin
            slot_free = !in_valid;
            if (in_valid && !o_in_stall) begin
                expected_q.insert(expected_q.size(), predict_event(in_data));
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (pending_q.size() != 0 && wait_cnt >= pending_q[0].gap) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_q[0].ev;
                    pending_q.delete(0);
                    wait_cnt <= 0;
                end else begin
                    in_valid <= 1'b0;
                    if (pending_q.size() != 0) wait_cnt <= wait_cnt + 1;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expectation, stall at random
    always @(posedge i_clk) begin : result_monitor
        int unsigned stall_left;
        int unsigned hold_left;
        bit          hold_done;
        t_out_item   want;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end else begin
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (o_out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t ns: result with no item pending, actual %p", $time,
                             o_out_data);
                    fail_cnt++;
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    check_field("phase", want.phase, o_out_data.phase);
                    check_field("slot_ms", want.slot_ms, o_out_data.slot_ms);
                    check_field("phase_changed", want.phase_changed, o_out_data.phase_changed);
                    check_field("old_phase", want.old_phase, o_out_data.old_phase);
                    check_field("aligned", want.aligned, o_out_data.aligned);
                    check_field("first_phase", want.first_phase, o_out_data.first_phase);
                    check_field("idle", want.idle, o_out_data.idle);
                end
                stall_left = quiet ? 0 : $urandom_range(0, 8);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            if (hold_left > 0) hold_left--;
            out_stall <= (stall_left > 0) || (hold_left > 0);
        end
    end

    task automatic queue_event(input logic [31:0] mono, input logic [26:0] day);
        t_pending p;
        p.ev.mono_ms = mono;
        p.ev.day_ms  = day;
        p.gap        = quiet ? 0 : $urandom_range(0, 8);
        pending_q.insert(pending_q.size(), p);
    endtask

    // Hold off until every item is accepted and answered, then let the block settle
    task automatic settle();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0 || o_out_valid)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; mirror the masked value
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODULE_COUNT: cfg_count   = val[2:0];
            REG_SLOT_LEN_0:   cfg_slot[0] = val[15:0];
            REG_SLOT_LEN_1:   cfg_slot[1] = val[15:0];
            REG_SLOT_LEN_2:   cfg_slot[2] = val[15:0];
            REG_SLOT_LEN_3:   cfg_slot[3] = val[15:0];
            REG_ALIGN_PERIOD: cfg_align   = val[15:0];
            REG_CLOCK_SKEW:   cfg_skew    = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] count, l0, l1, l2, l3, align, skew);
        reg_write(REG_MODULE_COUNT, count);
        reg_write(REG_SLOT_LEN_0, l0);
        reg_write(REG_SLOT_LEN_1, l1);
        reg_write(REG_SLOT_LEN_2, l2);
        reg_write(REG_SLOT_LEN_3, l3);
        reg_write(REG_ALIGN_PERIOD, align);
        reg_write(REG_CLOCK_SKEW, skew);
    endtask

    function automatic logic [31:0] pick_len(input int unsigned mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 50);
            default: begin
                case ($urandom_range(0, 2))
                    0: return 32'd0;
                    1: return 32'd1;
                    default: return 32'hFFFF;
                endcase
            end
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] mono, count, align, skew;
        int unsigned day, kind, advance;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No modules after reset: idle, phase forced to zero
        queue_event(32'd0, 27'd0);
        queue_event(32'hFFFF_FFFF, 27'h7FF_FFFF);
        settle();

        // Zero round: idle, no state change
        set_config(4, 0, 0, 0, 0, 1000, 0);
        queue_event(32'd3, 27'd500);
        settle();

        // First alignment, boundaries, period edge and monotonic wrap
        set_config(4, 100, 200, 300, 400, 1000, 0);
        queue_event(32'd5, 27'd0);
        queue_event(32'd50, 27'd40);
        queue_event(32'd100, 27'd90);
        queue_event(32'd150, 27'd140);
        queue_event(32'd1100, 27'd100);
        queue_event(32'd2100, 27'd1100);
        queue_event(32'd2101, 27'd999);
        queue_event(32'd2102, 27'd1000);
        queue_event(32'hFFFF_FFF0, 27'd86_399_999);
        queue_event(32'd5, 27'd3);
        settle();

        // Saturated count, most negative skew, zero period, longest slots
        set_config(7, 32'hFFFF_FFFF, 32'h0001_FFFF, 32'hFFFF, 32'hFFFF, 0, 32'hFFFF_8000);
        queue_event(32'd10, 27'd0);
        queue_event(32'd10, 27'h7FF_FFFF);
        queue_event(32'd11, 27'd232_768);
        settle();

        // Stale phase after shrinking the round; unused register and slots ignored
        set_config(2, 1, 0, 5, 7, 65535, 32'h0000_7FFF);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        queue_event(32'd20, 27'd0);
        queue_event(32'd21, 27'd5);
        queue_event(32'd21 + 32'd65536, 27'd86_399_999);
        settle();

        // Random phases: mostly advancing event streams, some noise
        for (int p = 0; p < RAND_PHASES; p++) begin
            count = p % 8;
            skew  = (p == 0) ? 32'h7FFF : (p == 1) ? 32'h8000 : $urandom;
            case (p % 4)
                0: align = 0;
                1: align = 32'hFFFF;
                default: align = $urandom_range(0, 3000);
            endcase
            set_config(count, pick_len(p % 3), pick_len(p % 3), pick_len(p % 3),
                       pick_len(p % 3), align, skew);
            quiet = (p % 4 == 3);
            mono  = (p % 3 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 20000) : $urandom;
            day   = $urandom_range(0, DAY_MS - 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    queue_event($urandom, 27'($urandom));
                end else begin
                    advance = (kind == 1) ? $urandom_range(0, 2 * cfg_align + 2)
                                          : $urandom_range(0, cfg_align / 4 + 4);
                    mono += advance;
                    day = (day + advance) % DAY_MS;
                    queue_event(mono, day[26:0]);
                end
            end
            // Long receiver hold while the sender keeps offering
            if (p == 4) hold_req = 1'b1;
            settle();
        end

        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### time_slot_phase_scheduler_unit.f
rtl/tsps_pkg.sv
rtl/tsps_mod_unit.sv
rtl/time_slot_phase_scheduler_unit.sv
tb/time_slot_phase_scheduler_unit_tb.sv
